/* src/kuwahara_edge_preserving_filter_assert.svh */
// Assertion macros for the Kuwahara filter block.
// Assumes the including module has clk and arst_n in scope.
`ifndef KUWAHARA_EDGE_PRESERVING_FILTER_ASSERT_SVH
`define KUWAHARA_EDGE_PRESERVING_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define KEPF_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("kepf assertion failed");
`define KEPF_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kepf assertion failed");
`define KEPF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kepf assertion failed");
`else
`define KEPF_ASSERT_ALWAYS(lbl, cond)
`define KEPF_ASSERT_IMPL(lbl, ante, cons)
`define KEPF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/kepf_pkg.sv */
// Package for the Kuwahara filter: constants, register codes, state type, luma function.
// No dependencies.
`default_nettype none
package kepf_pkg;
	localparam int DEF_RADIUS    = 2;
	localparam int DEF_MAX_WIDTH = 2048;
	localparam int CFG_W_BITS    = 12;
	localparam int CFG_H_BITS    = 13;
	localparam int ROW_BITS      = 13;
	localparam logic [CFG_W_BITS-1:0] RST_WIDTH  = 12'd2048;
	localparam logic [CFG_H_BITS-1:0] RST_HEIGHT = 13'd1080;
	localparam int LUMA_R = 19595;
	localparam int LUMA_G = 38470;
	localparam int LUMA_B = 7471;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ALPHA,
		ST_ROW_MUL,
		ST_ROW_INIT,
		ST_ROW_RED,
		ST_COL,
		ST_DRAIN,
		ST_VAR,
		ST_CMP,
		ST_OUT
	} kepf_state_t;

	function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		logic [24:0] acc;
		acc = 25'(r) * 25'(LUMA_R) + 25'(g) * 25'(LUMA_G) + 25'(b) * 25'(LUMA_B);
		return acc[23:16];
	endfunction
endpackage
`default_nettype wire

/* src/kuwahara_edge_preserving_filter.sv */
// Kuwahara edge-preserving filter over an RGBA raster stream.
// Uses kepf_pkg, kepf_ram and the assertion macro header.
//
// Input stream s_t*: one request per pixel (s_tuser = 0) or a flush
// request (s_tuser = 1). Output stream m_t*: filtered pixels, m_tlast on
// the last pixel of a frame. Configuration through the APB port: image
// width at byte address 0, image height at byte address 4.
// The result for a pixel appears once RADIUS*W + RADIUS further pixels have
// arrived; flush requests drain the remaining outputs one per request.
// A request that produces no output is taken without leaving the idle state.
// A request that produces one runs an alpha read, then per window row a
// multiply, an offset add and a reduction modulo the line store depth
// (reciprocal estimate, then one correction), followed by 2R+1 column reads;
// then a pipeline drain, a variance and a compare step per quadrant, and the
// output load. The line store is a single-port RAM read one window pixel per cycle.
// Reset clears positions, pointers and the pending count; the line store is
// not cleared. The output register holds a finished pixel while m_tready is
// low; the next request is taken meanwhile and waits only when its own result
// is ready and the register is still full.
`default_nettype none
`include "kuwahara_edge_preserving_filter_assert.svh"
module kuwahara_edge_preserving_filter
	import kepf_pkg::*;
#(
	parameter int RADIUS    = DEF_RADIUS,
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // in_red, in_green, in_blue, in_alpha
	input  wire logic        s_tuser,  // req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,  // out_red, out_green, out_blue, out_alpha
	output logic             m_tlast   // frame_end
);
	localparam int WIN   = 2 * RADIUS + 1;
	localparam int NQ    = (RADIUS + 1) * (RADIUS + 1);
	localparam int DEPTH = WIN * MAX_WIDTH;
	localparam int ADRW  = $clog2(DEPTH);
	localparam int COLW  = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int IW    = $clog2(WIN);
	localparam int PENDW = $clog2(RADIUS * MAX_WIDTH + RADIUS + 2);
	localparam int MAXM  = (2 ** ROW_BITS + RADIUS) * MAX_WIDTH;
	localparam int OFFM  = DEPTH * ((MAXM + DEPTH - 1) / DEPTH);
	localparam int XW    = $clog2(DEPTH + 2 * OFFM + 1);
	localparam int RCP   = (2 ** XW) / DEPTH;
	localparam int RCPW  = $clog2(RCP + 1);
	localparam int RW    = ROW_BITS + 2;
	localparam int MW    = RW + WW + 1;
	localparam int CW    = WW + 2;
	localparam int SUMW  = $clog2(NQ * 255 + 1);
	localparam int SQW   = $clog2(NQ * 65025 + 1);
	localparam int VARW  = $clog2(NQ * NQ * 65025 + 1);
	localparam int QS    = 2 * SUMW;
	localparam int QM    = (2 ** QS + NQ - 1) / NQ;
	localparam int QMW   = QS + 1;

	kepf_state_t state_q, state_d;

	logic [CFG_W_BITS-1:0] cfg_w_q;
	logic [CFG_H_BITS-1:0] cfg_h_q;
	logic [WW-1:0]         use_w;
	logic [ROW_BITS-1:0]   use_h;
	logic [13:0]           w_ext;
	logic [PENDW-1:0]      lag;

	logic [ADRW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PENDW-1:0]    pending_q;
	logic [COLW-1:0]     out_col_q;
	logic [ROW_BITS-1:0] out_row_q;

	logic accept, is_pix, need_emit, cfg_wr;

	logic [IW-1:0]        wi_q, wj_q;
	logic signed [MW-1:0] m_q;
	logic [XW-1:0]        x_q;
	logic [RCPW-1:0]      quo_q;
	logic                 k_q;
	logic [ADRW-1:0]      base_q;

	logic signed [RW-1:0] r_s, rr_s, drr_s;
	logic signed [MW-1:0] prod;
	logic signed [XW:0]   xs;
	logic [XW+RCPW-1:0]   qprod;
	logic [XW-1:0]        rem;
	logic [ADRW-1:0]      row_base;
	logic signed [CW-1:0] c_s, cc_s, dcc_s;
	logic signed [ADRW+1:0] a_s;
	logic [ADRW-1:0]      col_addr;

	logic            ram_we;
	logic [ADRW-1:0] ram_addr;
	logic [31:0]     ram_rdata;

	logic       v_s1, alpha_s1, v_s2;
	logic [3:0] mask_s1, mask_s2;
	logic [7:0] r_s2, g_s2, b_s2, l_s2;
	logic [7:0] alpha_q;

	logic [SUMW-1:0] sr_q [4];
	logic [SUMW-1:0] sg_q [4];
	logic [SUMW-1:0] sb_q [4];
	logic [SUMW-1:0] sl_q [4];
	logic [SQW-1:0]  sl2_q [4];
	logic [1:0]      qi_q;
	logic [VARW-1:0] var_q, min_var_q;
	logic [SUMW-1:0] bsr_q, bsg_q, bsb_q;

	logic [SUMW+QMW-1:0] mr, mg, mb;
	logic out_load, frame_end;
	logic m_tvalid_q;

	// Effective bounds
	always_comb begin
		w_ext = 14'(cfg_w_q);
		if (w_ext == 14'd0) begin
			use_w = WW'(1);
		end else if (w_ext > 14'(MAX_WIDTH)) begin
			use_w = WW'(MAX_WIDTH);
		end else begin
			use_w = WW'(w_ext);
		end
		use_h = (cfg_h_q == '0) ? ROW_BITS'(1) : cfg_h_q;
		lag   = PENDW'(RADIUS * int'(use_w) + RADIUS);
	end

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign is_pix   = (s_tuser == REQ_PIXEL);
	assign need_emit = is_pix ? ((PENDW + 1)'(pending_q) + 1'b1 > (PENDW + 1)'(lag))
		: (pending_q != '0);

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = 32'(cfg_w_q);
			REG_HEIGHT: prdata = 32'(cfg_h_q);
			default:    prdata = '0;
		endcase
	end

	// Row address: clamp row, offset times width, reduce modulo depth
	always_comb begin
		r_s = $signed({2'b00, out_row_q}) + $signed(RW'(wi_q)) - $signed(RW'(RADIUS));
		if (r_s < 0) begin
			rr_s = '0;
		end else if (r_s > $signed(RW'(use_h) - RW'(1))) begin
			rr_s = $signed(RW'(use_h) - RW'(1));
		end else begin
			rr_s = r_s;
		end
		drr_s  = rr_s - $signed({2'b00, out_row_q});
		prod   = MW'(drr_s) * $signed(MW'(use_w));
		xs     = $signed((XW + 1)'(rd_ptr_q)) + (XW + 1)'(m_q) + $signed((XW + 1)'(OFFM));
		// Quotient estimate is low by at most one, so one correction remains
		qprod  = (XW + RCPW)'(x_q) * (XW + RCPW)'(RCP);
		rem    = x_q - XW'(quo_q) * XW'(DEPTH);
		row_base = (rem >= XW'(DEPTH)) ? ADRW'(rem - XW'(DEPTH)) : ADRW'(rem);
	end

	// Column address: clamp column, add to row base with one wrap
	always_comb begin
		c_s = $signed(CW'(out_col_q)) + $signed(CW'(wj_q)) - $signed(CW'(RADIUS));
		if (c_s < 0) begin
			cc_s = '0;
		end else if (c_s > $signed(CW'(use_w) - CW'(1))) begin
			cc_s = $signed(CW'(use_w) - CW'(1));
		end else begin
			cc_s = c_s;
		end
		dcc_s = cc_s - $signed(CW'(out_col_q));
		a_s   = $signed((ADRW + 2)'(base_q)) + (ADRW + 2)'(dcc_s);
		if (a_s < 0) begin
			col_addr = ADRW'(a_s + $signed((ADRW + 2)'(DEPTH)));
		end else if (a_s >= $signed((ADRW + 2)'(DEPTH))) begin
			col_addr = ADRW'(a_s - $signed((ADRW + 2)'(DEPTH)));
		end else begin
			col_addr = ADRW'(a_s);
		end
	end

	always_comb begin
		ram_we = accept & is_pix;
		unique case (state_q)
			ST_IDLE:  ram_addr = wr_ptr_q;
			ST_ALPHA: ram_addr = rd_ptr_q;
			default:  ram_addr = col_addr;
		endcase
	end

	kepf_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(s_tdata),
		.rdata(ram_rdata)
	);

	assign out_load  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	assign frame_end = (out_row_q == use_h - ROW_BITS'(1)) &&
		(WW'(out_col_q) == use_w - WW'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && need_emit) begin
					state_d = ST_ALPHA;
				end
			end
			ST_ALPHA:    state_d = ST_ROW_MUL;
			ST_ROW_MUL:  state_d = ST_ROW_INIT;
			ST_ROW_INIT: state_d = ST_ROW_RED;
			ST_ROW_RED: begin
				if (k_q == '0) begin
					state_d = ST_COL;
				end
			end
			ST_COL: begin
				if (wj_q == IW'(WIN - 1)) begin
					state_d = (wi_q == IW'(WIN - 1)) ? ST_DRAIN : ST_ROW_MUL;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = ST_VAR;
				end
			end
			ST_VAR: state_d = ST_CMP;
			ST_CMP: state_d = (qi_q == 2'd3) ? ST_OUT : ST_VAR;
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cfg_w_q    <= RST_WIDTH;
			cfg_h_q    <= RST_HEIGHT;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			pending_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				unique case (paddr[2])
					REG_WIDTH:  cfg_w_q <= pwdata[CFG_W_BITS-1:0];
					REG_HEIGHT: cfg_h_q <= pwdata[CFG_H_BITS-1:0];
					default:    cfg_w_q <= cfg_w_q;
				endcase
			end
			if (ram_we) begin
				wr_ptr_q  <= (wr_ptr_q == ADRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
				pending_q <= pending_q + 1'b1;
			end
			v_s1 <= (state_q == ST_ALPHA) || (state_q == ST_COL);
			v_s2 <= v_s1 && !alpha_s1;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				rd_ptr_q   <= (rd_ptr_q == ADRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				pending_q  <= pending_q - 1'b1;
				if (WW'(out_col_q) + WW'(1) >= use_w) begin
					out_col_q <= '0;
					out_row_q <= (out_row_q + ROW_BITS'(1) >= use_h) ? '0
						: out_row_q + ROW_BITS'(1);
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_ALPHA) begin
			wi_q <= '0;
		end
		if (state_q == ST_ROW_MUL) begin
			m_q  <= prod;
			wj_q <= '0;
		end
		if (state_q == ST_ROW_INIT) begin
			x_q <= xs[XW-1:0];
			k_q <= 1'b1;
		end
		if (state_q == ST_ROW_RED) begin
			k_q <= 1'b0;
			if (k_q) begin
				quo_q <= qprod[XW +: RCPW];
			end else begin
				base_q <= row_base;
			end
		end
		if (state_q == ST_COL) begin
			wj_q <= wj_q + 1'b1;
			if (wj_q == IW'(WIN - 1)) begin
				wi_q <= wi_q + 1'b1;
			end
		end

		alpha_s1   <= (state_q == ST_ALPHA);
		mask_s1[0] <= (wi_q <= IW'(RADIUS)) && (wj_q <= IW'(RADIUS));
		mask_s1[1] <= (wi_q <= IW'(RADIUS)) && (wj_q >= IW'(RADIUS));
		mask_s1[2] <= (wi_q >= IW'(RADIUS)) && (wj_q <= IW'(RADIUS));
		mask_s1[3] <= (wi_q >= IW'(RADIUS)) && (wj_q >= IW'(RADIUS));

		if (v_s1 && alpha_s1) begin
			alpha_q <= ram_rdata[31:24];
		end
		mask_s2 <= mask_s1;
		r_s2    <= ram_rdata[7:0];
		g_s2    <= ram_rdata[15:8];
		b_s2    <= ram_rdata[23:16];
		l_s2    <= luma(ram_rdata[7:0], ram_rdata[15:8], ram_rdata[23:16]);

		// Clear sums at the start of a window, accumulate per quadrant
		for (int q = 0; q < 4; q++) begin
			if (state_q == ST_ALPHA) begin
				sr_q[q]  <= '0;
				sg_q[q]  <= '0;
				sb_q[q]  <= '0;
				sl_q[q]  <= '0;
				sl2_q[q] <= '0;
			end else if (v_s2 && mask_s2[q]) begin
				sr_q[q]  <= sr_q[q] + SUMW'(r_s2);
				sg_q[q]  <= sg_q[q] + SUMW'(g_s2);
				sb_q[q]  <= sb_q[q] + SUMW'(b_s2);
				sl_q[q]  <= sl_q[q] + SUMW'(l_s2);
				sl2_q[q] <= sl2_q[q] + SQW'(16'(l_s2) * 16'(l_s2));
			end
		end

		if (state_q == ST_DRAIN) begin
			qi_q <= '0;
		end
		if (state_q == ST_VAR) begin
			var_q <= VARW'(NQ) * VARW'(sl2_q[qi_q]) - VARW'(sl_q[qi_q]) * VARW'(sl_q[qi_q]);
		end
		if (state_q == ST_CMP) begin
			// Earlier quadrant keeps a tie
			if (qi_q == 2'd0 || var_q < min_var_q) begin
				min_var_q <= var_q;
				bsr_q     <= sr_q[qi_q];
				bsg_q     <= sg_q[qi_q];
				bsb_q     <= sb_q[qi_q];
			end
			qi_q <= qi_q + 1'b1;
		end
		if (out_load) begin
			m_tdata <= {alpha_q, mb[QS +: 8], mg[QS +: 8], mr[QS +: 8]};
			m_tlast <= frame_end;
		end
	end

	// Truncated means by reciprocal, exact over the sum range
	assign mr = (SUMW + QMW)'(bsr_q) * (SUMW + QMW)'(QMW'(QM));
	assign mg = (SUMW + QMW)'(bsg_q) * (SUMW + QMW)'(QMW'(QM));
	assign mb = (SUMW + QMW)'(bsb_q) * (SUMW + QMW)'(QMW'(QM));

	assign m_tvalid = m_tvalid_q;

	`KEPF_ASSERT_IMPL(a_store_write_idle, ram_we, state_q == ST_IDLE)
	`KEPF_ASSERT_IMPL(a_addr_in_range, state_q == ST_COL, ram_addr <= ADRW'(DEPTH - 1))
	`KEPF_ASSERT_ALWAYS(a_pending_bound, pending_q <= PENDW'(RADIUS * MAX_WIDTH + RADIUS + 1))
	`KEPF_ASSERT_NEXT(a_out_loaded, out_load, m_tvalid && state_q == ST_IDLE)
endmodule
`default_nettype wire

/* src/kepf_ram.sv */
// Generic single-port RAM, registered read.
// No dependencies.
`default_nettype none
module kepf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

/* tb/kuwahara_edge_preserving_filter_tb.sv */
// Self-checking testbench for the Kuwahara filter: streams RGBA pixels and flush
// requests, predicts every filtered pixel and compares it with the output stream.
// Depends on kepf_pkg and the kuwahara_edge_preserving_filter top level.
`timescale 1ns / 1ps

typedef struct packed {
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic       frame_end;
} filtered_px_t;

class kuwahara_scoreboard;
	localparam int R = kepf_pkg::DEF_RADIUS;
	localparam int DEPTH = (2 * R + 1) * kepf_pkg::DEF_MAX_WIDTH;
	localparam int NQ = (R + 1) * (R + 1);

	logic [31:0]  pix_mem[DEPTH];
	bit           written[DEPTH];
	int unsigned  width_reg, height_reg;
	int unsigned  in_col, in_row, out_col, out_row;
	int unsigned  wr_ptr, rd_ptr, pending;
	filtered_px_t expected_q[$];
	int           errors, checked;

	function new();
		width_reg = kepf_pkg::RST_WIDTH;
		height_reg = kepf_pkg::RST_HEIGHT;
	endfunction

	function void set_reg(logic idx, logic [31:0] value);
		if (idx == kepf_pkg::REG_WIDTH)
			width_reg = value[11:0];
		else
			height_reg = value[12:0];
	endfunction

	function int unsigned use_w();
		if (width_reg < 1)
			return 1;
		return (width_reg > DEPTH / (2 * R + 1)) ? DEPTH / (2 * R + 1) : width_reg;
	endfunction

	function int unsigned use_h();
		return (height_reg < 1) ? 1 : height_reg;
	endfunction

	function void step_pos(inout int unsigned col, inout int unsigned row);
		if (col + 1 >= use_w()) begin
			col = 0;
			row = (row + 1 >= use_h()) ? 0 : row + 1;
		end else begin
			col = col + 1;
		end
	endfunction

	// clamp to the frame, then locate the pixel relative to the read pointer
	function int unsigned slot_of(longint r, longint c);
		longint w, h, rr, cc, idx;
		w = use_w();
		h = use_h();
		rr = (r < 0) ? 0 : ((r > h - 1) ? h - 1 : r);
		cc = (c < 0) ? 0 : ((c > w - 1) ? w - 1 : c);
		idx = (longint'(rd_ptr) + (rr - longint'(out_row)) * w
			+ (cc - longint'(out_col))) % DEPTH;
		if (idx < 0)
			idx += DEPTH;
		return int'(idx);
	endfunction

	// true when nothing is pending or every pixel of the next window has been stored at some point
	function bit window_ready();
		if (pending == 0)
			return 1;
		for (int q = 0; q < 4; q++)
			for (int dy = 0; dy <= R; dy++)
				for (int dx = 0; dx <= R; dx++)
					if (!written[slot_of(longint'(out_row) + (q[1] ? 0 : -R) + dy,
							longint'(out_col) + (q[0] ? 0 : -R) + dx)])
						return 0;
		return 1;
	endfunction

	function void emit_pixel();
		filtered_px_t px;
		longint min_var, var_q, sl, sl2;
		int unsigned sr, sg, sb, lum;
		logic [31:0] p;
		min_var = 0;
		px = '0;
		for (int q = 0; q < 4; q++) begin
			sr = 0; sg = 0; sb = 0; sl = 0; sl2 = 0;
			for (int dy = 0; dy <= R; dy++)
				for (int dx = 0; dx <= R; dx++) begin
					p = pix_mem[slot_of(longint'(out_row) + (q[1] ? 0 : -R) + dy,
						longint'(out_col) + (q[0] ? 0 : -R) + dx)];
					lum = (19595 * p[7:0] + 38470 * p[15:8] + 7471 * p[23:16]) >> 16;
					sr += p[7:0];
					sg += p[15:8];
					sb += p[23:16];
					sl += lum;
					sl2 += lum * lum;
				end
			var_q = NQ * sl2 - sl * sl;
			// earlier quadrant keeps a tie
			if (q == 0 || var_q < min_var) begin
				min_var = var_q;
				px.red = 8'(sr / NQ);
				px.green = 8'(sg / NQ);
				px.blue = 8'(sb / NQ);
			end
		end
		px.alpha = pix_mem[rd_ptr][31:24];
		px.frame_end = (out_row == use_h() - 1) && (out_col == use_w() - 1);
		expected_q.push_back(px);
		step_pos(out_col, out_row);
		rd_ptr = (rd_ptr + 1) % DEPTH;
		pending--;
	endfunction

	function void note_request(logic kind, logic [31:0] data);
		int unsigned lag;
		lag = R * use_w() + R;
		if (kind == kepf_pkg::REQ_PIXEL) begin
			pix_mem[wr_ptr] = data;
			written[wr_ptr] = 1;
			wr_ptr = (wr_ptr + 1) % DEPTH;
			step_pos(in_col, in_row);
			pending++;
			if (pending > lag)
				emit_pixel();
		end else if (pending > 0) begin
			emit_pixel();
		end
	endfunction

	function void check_pixel(logic [31:0] data, logic last);
		filtered_px_t want;
		if (expected_q.size() == 0) begin
			$error("unexpected output pixel data=%h last=%0b", data, last);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		checked++;
		if (data[7:0] !== want.red) begin
			$error("out_red expected %0d got %0d", want.red, data[7:0]);
			errors++;
		end
		if (data[15:8] !== want.green) begin
			$error("out_green expected %0d got %0d", want.green, data[15:8]);
			errors++;
		end
		if (data[23:16] !== want.blue) begin
			$error("out_blue expected %0d got %0d", want.blue, data[23:16]);
			errors++;
		end
		if (data[31:24] !== want.alpha) begin
			$error("out_alpha expected %0d got %0d", want.alpha, data[31:24]);
			errors++;
		end
		if (last !== want.frame_end) begin
			$error("frame_end expected %0b got %0b", want.frame_end, last);
			errors++;
		end
	endfunction
endclass

module kuwahara_edge_preserving_filter_tb;
	import kepf_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE = 250;
	localparam int HOLD_CYCLES = 600;
	localparam int RANDOM_ITEMS = 1900;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // in_red, in_green, in_blue, in_alpha
	logic        s_tuser = 1'b0; // req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // out_red, out_green, out_blue, out_alpha
	logic        m_tlast;        // frame_end

	kuwahara_scoreboard sb = new();
	int unsigned cycles = 0;
	int          send_idle_pct = 31, recv_idle_pct = 45;
	int          hold_asks = 0, hold_seen = 0, hold_left = 0;
	int          item_count = 0, pixel_count = 0, flush_count = 0;

	kuwahara_edge_preserving_filter u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_pixel(m_tdata, m_tlast);

	// receiver: random backpressure, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_asks != hold_seen) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic reg_write(logic idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {1'b0, idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_request(logic kind, logic [31:0] data);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		if (kind == REQ_PIXEL || sb.pending > 0)
			item_count++;
		if (kind == REQ_PIXEL)
			pixel_count++;
		else
			flush_count++;
		sb.note_request(kind, data);
		// switch idling pattern as the random part advances
		if (item_count > RANDOM_ITEMS) begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end else if (item_count > RANDOM_ITEMS / 2) begin
			send_idle_pct = 45;
			recv_idle_pct = 31;
		end
	endtask

	function automatic logic [31:0] random_pixel();
		logic [31:0] p;
		p = $urandom();
		// near-flat pixels make equal variances more likely
		if ($urandom_range(9) < 3)
			p[23:0] = {3{8'h40 | 8'($urandom_range(1))}};
		return p;
	endfunction

	task automatic random_items(int n);
		repeat (n) begin
			if ($urandom_range(9) == 0 && sb.window_ready())
				send_request(REQ_FLUSH, $urandom());
			else
				send_request(REQ_PIXEL, random_pixel());
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// complete the current frame, then drain everything still pending
	task automatic close_frame();
		while (sb.in_col != 0 || sb.in_row != 0)
			send_request(REQ_PIXEL, random_pixel());
		while (sb.pending > 0)
			send_request(REQ_FLUSH, $urandom());
		wait_drained();
	endtask

	initial begin
		int wlist[8] = '{0, 5, 3, 4095, 2, 16, 1, 6};
		int hlist[8] = '{0, 4, 8191, 1, 7, 3, 9, 6};
		logic [31:0] corners[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_00FF,
			32'h0100_FF00, 32'hFEFF_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h00FF_FFFF};
		int phases;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: one-row frame, flush with nothing pending, early flushes
		reg_write(REG_WIDTH, 8);
		reg_write(REG_HEIGHT, 1);
		send_request(REQ_FLUSH, 32'hFFFF_FFFF);
		for (int i = 0; i < 6; i++)
			send_request(REQ_PIXEL, corners[i]);
		send_request(REQ_FLUSH, 32'h0);
		send_request(REQ_FLUSH, 32'h1234_5678);
		send_request(REQ_PIXEL, corners[6]);
		send_request(REQ_PIXEL, corners[7]);
		close_frame();
		phases = 1;

		for (int i = 0; i < 8; i++) begin
			reg_write(REG_WIDTH, wlist[i]);
			reg_write(REG_HEIGHT, hlist[i]);
			if (hlist[i] == 8191) begin
				// tall frame cut short: shrink height while mid-frame
				random_items(60);
				wait_drained();
				reg_write(REG_HEIGHT, sb.in_row + 1);
			end else if (wlist[i] == 4095) begin
				// clamped maximum width, then cut the row short
				random_items(10);
				wait_drained();
				reg_write(REG_WIDTH, sb.in_col + 1);
			end else if (i == 1) begin
				random_items(80);
				hold_asks++;
				random_items(120);
			end else begin
				random_items(180);
			end
			close_frame();
			phases++;
		end

		while (item_count < RANDOM_ITEMS + 25) begin
			reg_write(REG_WIDTH, $urandom_range(12, 1));
			reg_write(REG_HEIGHT, $urandom_range(6, 1));
			random_items($urandom_range(200, 80));
			close_frame();
			phases++;
		end

		$display("%0d pixels and %0d flush requests over %0d frame settings,",
			pixel_count, flush_count, phases);
		$display("%0d filtered pixels compared, %0d still outstanding",
			sb.checked, sb.expected_q.size());
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

/* sim.f */
+incdir+src
src/kepf_pkg.sv
src/kepf_ram.sv
src/kuwahara_edge_preserving_filter.sv
tb/kuwahara_edge_preserving_filter_tb.sv
